@@ rtl/lrc_frame_deframer_defines.svh @@
// assertion macros for the lrc frame deframer
`ifndef LRC_FRAME_DEFRAMER_DEFINES_SVH
`define LRC_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define LFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lfd assertion failed");

// condition that must never be true out of reset
`define LFD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lfd forbidden condition seen");

`else

`define LFD_ASSERT(lbl, clk, rst_n, prop)
`define LFD_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/lfd_pkg.sv @@
// types and constants of the lrc frame deframer
package lfd_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SOF,
        ST_HDR,
        ST_CHECK,
        ST_COPY,
        ST_DONE
    } t_state;

    // command codes carried in tuser
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [7:0] SOF_BYTE       = 8'h11;
    localparam int         HDR_TRL_BYTES  = 10;
    localparam logic [3:0] FIRST_HDR_OFF  = 4'd2;
    localparam logic [3:0] LRC_OFF        = 4'd8;
    localparam int         PAYLOAD_OFF    = 9;
    localparam logic [15:0] STATUS_RESET  = 16'hFFFF;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

endpackage

@@ rtl/lrc_frame_deframer.sv @@
// lrc frame deframer: receive ring buffer, header hunt and lrc check, payload store
//
// input stream: one word per command. tuser[0] selects a push of a received
// byte (0) or a read of one latched payload byte (1). one result word per
// command on the output stream, held in an output register until taken.
// a push is written into a ring buffer memory, then a sequencer scans the
// head of the buffer through the single read port: it drops non-start
// bytes, sums and checks each header candidate, and copies an accepted
// payload into the payload memory. a push ends without a copy when fewer
// than 10 bytes are held or when a pending frame still waits for bytes.
// one command is in work at a time; the next one is taken once the result
// is in the output register. when the receiver stalls, the block finishes
// the command at hand and then holds it until the output register frees up.
// reset empties the buffer (head and count only), clears the latched
// command and length and sets the latched status to all ones; memory
// contents need no clearing since nothing is read before it is written.
`include "lrc_frame_deframer_defines.svh"

module lrc_frame_deframer
    import lfd_pkg::*;
#(
    parameter int BUFFER_BYTES  = 512,
    parameter int PAYLOAD_BYTES = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // rx_byte [7:0], read_index [16:8], zero [23:17]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd [0]
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // frame_ready [0], frame_command [16:1], frame_status [32:17],
    // frame_length [41:33], buffer_cleared [42], read_data [50:43], zero [55:51]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int OW = AW + 1;
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int LW = $clog2(BUFFER_BYTES);
    localparam int PW = $clog2(PAYLOAD_BYTES);
    localparam int NW = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [OW-1:0] BUF_W = OW'(BUFFER_BYTES);

    // ring index of base + off
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [OW-1:0] off);
        logic [OW-1:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= BUF_W) begin
            sum = sum - BUF_W;
        end
        return sum[AW-1:0];
    endfunction

    logic [7:0] r_buf_mem [BUFFER_BYTES];
    logic [7:0] r_pay_mem [PAYLOAD_BYTES];
    logic [7:0] r_buf_q;
    logic [7:0] r_pay_q;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [15:0]      r_lat_cmd, n_lat_cmd;
    logic [15:0]      r_lat_sts, n_lat_sts;
    logic [LW-1:0]    r_lat_len, n_lat_len;
    logic             r_is_read, n_is_read;
    logic             r_hit, n_hit;
    logic             r_ready, n_ready;
    logic             r_cleared, n_cleared;
    logic [3:0]       r_off, n_off;
    logic [7:0]       r_sum, n_sum;
    logic [47:0]      r_hdr, n_hdr;
    logic [AW-1:0]    r_cbase, n_cbase;
    logic [NW-1:0]    r_ncopy, n_ncopy;
    logic [NW-1:0]    r_ci, n_ci;
    logic             r_wv, n_wv;
    logic [PW-1:0]    r_wi, n_wi;
    logic             r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic             w_accept;
    logic             w_cmd;
    logic [7:0]       w_rx;
    logic [8:0]       w_ridx;
    logic             w_buf_we;
    logic [AW-1:0]    w_buf_waddr;
    logic             w_buf_re;
    logic [AW-1:0]    w_buf_raddr;
    logic             w_pay_re;
    logic [15:0]      w_len16;
    logic [15:0]      w_dlen;
    logic [16:0]      w_total;
    logic [7:0]       w_rdata;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = s_axis_tuser[0];
    assign w_rx          = s_axis_tdata[7:0];
    assign w_ridx        = s_axis_tdata[16:8];
    assign w_dlen        = r_hdr[15:0];
    assign w_total       = 17'(w_dlen) + 17'(HDR_TRL_BYTES);
    assign w_len16       = 16'(r_lat_len);
    assign w_rdata       = (r_is_read && r_hit) ? r_pay_q : 8'd0;
    assign w_pay_re      = w_accept && (w_cmd == CMD_READ);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // memories
    always_ff @(posedge i_clk) begin
        if (w_buf_we) begin
            r_buf_mem[w_buf_waddr] <= w_rx;
        end
        if (w_buf_re) begin
            r_buf_q <= r_buf_mem[w_buf_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wv) begin
            r_pay_mem[r_wi] <= r_buf_q;
        end
        if (w_pay_re) begin
            r_pay_q <= r_pay_mem[PW'(w_ridx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_lat_cmd   <= '0;
            r_lat_sts   <= STATUS_RESET;
            r_lat_len   <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_lat_cmd   <= n_lat_cmd;
            r_lat_sts   <= n_lat_sts;
            r_lat_len   <= n_lat_len;
            r_wv        <= n_wv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_read  <= n_is_read;
        r_hit      <= n_hit;
        r_ready    <= n_ready;
        r_cleared  <= n_cleared;
        r_off      <= n_off;
        r_sum      <= n_sum;
        r_hdr      <= n_hdr;
        r_cbase    <= n_cbase;
        r_ncopy    <= n_ncopy;
        r_ci       <= n_ci;
        r_wi       <= n_wi;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_lat_cmd   = r_lat_cmd;
        n_lat_sts   = r_lat_sts;
        n_lat_len   = r_lat_len;
        n_is_read   = r_is_read;
        n_hit       = r_hit;
        n_ready     = r_ready;
        n_cleared   = r_cleared;
        n_off       = r_off;
        n_sum       = r_sum;
        n_hdr       = r_hdr;
        n_cbase     = r_cbase;
        n_ncopy     = r_ncopy;
        n_ci        = r_ci;
        n_wv        = 1'b0;
        n_wi        = r_wi;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        w_buf_we    = 1'b0;
        w_buf_waddr = wrap_add(r_head, OW'(r_count));
        w_buf_re    = 1'b0;
        w_buf_raddr = r_head;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_is_read = (w_cmd == CMD_READ);
                    n_hit     = (16'(w_ridx) < w_len16) &&
                                (16'(w_ridx) < 16'(PAYLOAD_BYTES));
                    n_ready   = 1'b0;
                    n_cleared = 1'b0;
                    if (w_cmd == CMD_PUSH) begin
                        w_buf_we = 1'b1;
                        if (r_count == CW'(BUFFER_BYTES)) begin
                            // full buffer is emptied before the store
                            n_cleared   = 1'b1;
                            w_buf_waddr = r_head;
                            n_count     = CW'(1);
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (r_count < CW'(HDR_TRL_BYTES)) begin
                    n_state = ST_DONE;
                end else begin
                    w_buf_re    = 1'b1;
                    w_buf_raddr = r_head;
                    n_state     = ST_SOF;
                end
            end
            ST_SOF: begin
                if (r_buf_q != SOF_BYTE) begin
                    n_head  = wrap_add(r_head, OW'(1));
                    n_count = r_count - CW'(1);
                    n_state = ST_SCAN;
                end else begin
                    n_sum       = 8'd0;
                    w_buf_re    = 1'b1;
                    w_buf_raddr = wrap_add(r_head, OW'(FIRST_HDR_OFF));
                    n_off       = FIRST_HDR_OFF;
                    n_state     = ST_HDR;
                end
            end
            ST_HDR: begin
                // data in r_buf_q is the byte at offset r_off
                n_sum = r_sum + r_buf_q;
                if (r_off != LRC_OFF) begin
                    n_hdr       = {r_hdr[39:0], r_buf_q};
                    w_buf_re    = 1'b1;
                    w_buf_raddr = wrap_add(r_head, OW'(r_off + 4'd1));
                    n_off       = r_off + 4'd1;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_total > 17'(BUFFER_BYTES)) begin
                    n_count   = '0;
                    n_cleared = 1'b1;
                    n_state   = ST_SCAN;
                end else if (17'(r_count) < w_total) begin
                    n_state = ST_DONE;
                end else if (r_sum != 8'd0) begin
                    // bytes 2..8 sum to zero when the header lrc matches
                    n_head  = wrap_add(r_head, OW'(1));
                    n_count = r_count - CW'(1);
                    n_state = ST_SCAN;
                end else begin
                    n_lat_cmd = r_hdr[47:32];
                    n_lat_sts = r_hdr[31:16];
                    n_lat_len = LW'(w_dlen);
                    n_ready   = 1'b1;
                    n_cbase   = wrap_add(r_head, OW'(PAYLOAD_OFF));
                    n_ncopy   = (w_dlen < 16'(PAYLOAD_BYTES)) ? NW'(w_dlen)
                                                              : NW'(PAYLOAD_BYTES);
                    n_ci      = '0;
                    n_head    = wrap_add(r_head, OW'(w_total));
                    n_count   = r_count - CW'(w_total);
                    n_state   = ST_COPY;
                end
            end
            ST_COPY: begin
                if (r_ci < r_ncopy) begin
                    w_buf_re    = 1'b1;
                    w_buf_raddr = wrap_add(r_cbase, OW'(r_ci));
                    n_wv        = 1'b1;
                    n_wi        = PW'(r_ci);
                    n_ci        = r_ci + NW'(1);
                end else if (!r_wv) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {5'd0, w_rdata, r_cleared, w_len16[8:0],
                                   r_lat_sts, r_lat_cmd, r_ready};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `LFD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(BUFFER_BYTES))
    `LFD_ASSERT(a_hdr_enough_bytes, i_clk, i_rst_n,
                (r_state == ST_HDR) |-> (r_count >= CW'(HDR_TRL_BYTES)))
    `LFD_NEVER(a_copy_no_push, i_clk, i_rst_n, (r_state == ST_COPY) && w_buf_we)
    `LFD_ASSERT(a_done_loads_out, i_clk, i_rst_n,
                ((r_state == ST_DONE) && (!r_out_valid || m_axis_tready))
                |=> (r_out_valid && (r_state == ST_IDLE)))

endmodule
